// ===== rtl/sfir_pkg.sv =====
// ----------------------------------------------------------------------------
// sfir_pkg: shared types and coefficient tables
// Coefficient ROMs (signed Q1.17), lane control struct and default parameters
// for the stereo switchable FIR.
// ----------------------------------------------------------------------------
package sfir_pkg;

  // default configuration
  localparam int MAX_TAPS_DEF     = 21;
  localparam int LOWPASS_TAPS_DEF = 20;
  localparam int COEF_WIDTH_DEF   = 18;
  localparam int SAMPLE_WIDTH_DEF = 24;

  // coefficient rom geometry
  localparam int ROM_WIDTH = 18;
  localparam int LP_LEN    = 20;
  localparam int HP_LEN    = 21;
  localparam int ROM_IDX_W = 5;

  // bit positions in the switch word
  localparam int KIND_LP_BIT = 0;
  localparam int KIND_HP_BIT = 1;

  // per-cycle commands from the sequencer to both lanes
  typedef struct packed {
    logic push;     // shift the new sample into the delay line
    logic clear;    // clear the accumulator
    logic issue;    // read one tap and multiply
    logic lowpass;  // select the low-pass table
    logic finish;   // truncate toward zero, saturate and capture the lane result
    logic bypass;   // capture the newest sample instead of the sum
  } sfir_ctrl_t;

  // low-pass taps, Q1.17
  function automatic logic signed [ROM_WIDTH-1:0] lp_coef(input logic [ROM_IDX_W-1:0] idx);
    logic signed [ROM_WIDTH-1:0] c;
    case (idx)
      5'd0:    c = -18'sd2218;
      5'd1:    c = 18'sd6611;
      5'd2:    c = 18'sd5159;
      5'd3:    c = 18'sd5690;
      5'd4:    c = 18'sd6734;
      5'd5:    c = 18'sd7841;
      5'd6:    c = 18'sd8846;
      5'd7:    c = 18'sd9672;
      5'd8:    c = 18'sd10256;
      5'd9:    c = 18'sd10555;
      5'd10:   c = 18'sd10555;
      5'd11:   c = 18'sd10256;
      5'd12:   c = 18'sd9672;
      5'd13:   c = 18'sd8846;
      5'd14:   c = 18'sd7841;
      5'd15:   c = 18'sd6734;
      5'd16:   c = 18'sd5690;
      5'd17:   c = 18'sd5159;
      5'd18:   c = 18'sd6611;
      5'd19:   c = -18'sd2218;
      default: c = '0;
    endcase
    return c;
  endfunction

  // high-pass taps, Q1.17
  function automatic logic signed [ROM_WIDTH-1:0] hp_coef(input logic [ROM_IDX_W-1:0] idx);
    logic signed [ROM_WIDTH-1:0] c;
    case (idx)
      5'd0:    c = -18'sd5167;
      5'd1:    c = -18'sd777;
      5'd2:    c = 18'sd1876;
      5'd3:    c = 18'sd5333;
      5'd4:    c = 18'sd7553;
      5'd5:    c = 18'sd6349;
      5'd6:    c = 18'sd570;
      5'd7:    c = -18'sd9087;
      5'd8:    c = -18'sd20026;
      5'd9:    c = -18'sd28670;
      5'd10:   c = 18'sd99118;
      5'd11:   c = -18'sd28670;
      5'd12:   c = -18'sd20026;
      5'd13:   c = -18'sd9087;
      5'd14:   c = 18'sd570;
      5'd15:   c = 18'sd6349;
      5'd16:   c = 18'sd7553;
      5'd17:   c = 18'sd5333;
      5'd18:   c = 18'sd1876;
      5'd19:   c = -18'sd777;
      5'd20:   c = -18'sd5167;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/stereo_switchable_fir.sv =====
// ----------------------------------------------------------------------------
// stereo_switchable_fir: switchable low-pass / high-pass stereo FIR
// Two lanes, one per channel, each with its own delay line and multiplier,
// stepped through the taps by a shared sequencer; the results are merged
// into one output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_ready_o carry a stereo frame and a switch
//   word (bit 0 low-pass, else bit 1 high-pass, else bypass). Output channel:
//   out_valid_o / out_ready_i carry the left and right results.
//   Every frame is shifted into both delay lines, whatever the mode.
//   Sequence: an accepted filtered frame walks S_RUN over its N taps (20
//   low-pass, 21 high-pass at default settings), then S_DRAIN, S_FIN and
//   S_LOAD into the output register; a bypass frame goes straight to S_FIN
//   and S_LOAD. No new frame is taken until the current one is loaded; the
//   pace is set by the single multiply-accumulate per lane that walks the
//   taps one per cycle.
//   The next frame is accepted while a finished result still waits in the
//   output register; a stalled receiver holds the sequencer only when the
//   following result is ready to be written.
//   Reset clears both delay lines, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module stereo_switchable_fir
  import sfir_pkg::*;
#(
  parameter int MAX_TAPS     = MAX_TAPS_DEF,
  parameter int LOWPASS_TAPS = LOWPASS_TAPS_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_left_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_right_i,
  input  logic [1:0]                     kind_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_o
);

  localparam int TapW    = $clog2(MAX_TAPS);
  localparam int LpMin   = (LOWPASS_TAPS < LP_LEN) ? LOWPASS_TAPS : LP_LEN;
  localparam int LpCount = (LpMin < MAX_TAPS) ? LpMin : MAX_TAPS;
  localparam int HpCount = (MAX_TAPS < HP_LEN) ? MAX_TAPS : HP_LEN;
  localparam logic [TapW-1:0] LpLast = TapW'(LpCount - 1);
  localparam logic [TapW-1:0] HpLast = TapW'(HpCount - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FIN,
    S_LOAD
  } state_e;

  state_e                         state_q;
  logic [TapW-1:0]                tap_q;
  logic                           lowpass_q;
  logic                           bypass_q;
  logic                           accept;
  logic                           merge_free;
  logic                           load;
  logic [TapW-1:0]                tap_last;
  sfir_ctrl_t                     ctrl;
  logic signed [SAMPLE_WIDTH-1:0] left_res, right_res;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign tap_last   = lowpass_q ? LpLast : HpLast;
  assign load       = (state_q == S_LOAD) && merge_free;

  // lane commands
  always_comb begin
    ctrl         = '0;
    ctrl.push    = accept;
    ctrl.clear   = accept;
    ctrl.issue   = (state_q == S_RUN);
    ctrl.lowpass = lowpass_q;
    ctrl.finish  = (state_q == S_FIN);
    ctrl.bypass  = bypass_q;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tap_q     <= '0;
      lowpass_q <= 1'b0;
      bypass_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            tap_q     <= '0;
            lowpass_q <= kind_i[KIND_LP_BIT];
            bypass_q  <= !kind_i[KIND_LP_BIT] && !kind_i[KIND_HP_BIT];
            state_q   <= (!kind_i[KIND_LP_BIT] && !kind_i[KIND_HP_BIT]) ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          if (tap_q == tap_last) begin
            state_q <= S_DRAIN;
          end else begin
            tap_q <= tap_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (merge_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // left lane
  sfir_lane #(
    .MAX_TAPS     (MAX_TAPS),
    .COEF_WIDTH   (COEF_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lane_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .tap_idx_i (tap_q),
    .sample_i  (sample_left_i),
    .result_o  (left_res)
  );

  // right lane
  sfir_lane #(
    .MAX_TAPS     (MAX_TAPS),
    .COEF_WIDTH   (COEF_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lane_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .tap_idx_i (tap_q),
    .sample_i  (sample_right_i),
    .result_o  (right_res)
  );

  // output register
  sfir_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .left_i      (left_res),
    .right_i     (right_res),
    .free_o      (merge_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o)
  );

endmodule

// ===== rtl/sfir_lane.sv =====
// ----------------------------------------------------------------------------
// sfir_lane: one channel of the filter
// Delay line, coefficient lookup, one multiplier and a saturating
// accumulator, followed by truncation toward zero and output saturation.
// ----------------------------------------------------------------------------
module sfir_lane
  import sfir_pkg::*;
#(
  parameter int MAX_TAPS     = MAX_TAPS_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int TapW        = $clog2(MAX_TAPS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sfir_ctrl_t                     ctrl_i,
  input  logic [TapW-1:0]                tap_idx_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] result_o
);

  localparam int PW     = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int AccRaw = PW + TapW + 1;
  localparam int AccW   = (AccRaw > 64) ? 64 : AccRaw;
  localparam int FracW  = COEF_WIDTH - 1;
  localparam int QW     = AccW - FracW;
  localparam logic [AccW-1:0] BiasMask = {{(AccW-FracW){1'b0}}, {FracW{1'b1}}};
  localparam logic signed [QW-1:0] SatMax = {{(QW-SAMPLE_WIDTH+1){1'b0}},
                                             {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [QW-1:0] SatMin = ~SatMax;

  logic signed [SAMPLE_WIDTH-1:0] hist_q [MAX_TAPS];
  logic [ROM_IDX_W-1:0]           rom_idx;
  logic signed [ROM_WIDTH-1:0]    rom_q;
  logic signed [COEF_WIDTH-1:0]   coef;
  logic signed [PW-1:0]           prod_d, prod_q;
  logic                           prod_v_q;
  logic signed [AccW-1:0]         acc_d, acc_q;
  logic signed [AccW:0]           sum;
  logic signed [AccW-1:0]         biased;
  logic signed [QW-1:0]           quot;
  logic signed [SAMPLE_WIDTH-1:0] sat_val;
  logic signed [SAMPLE_WIDTH-1:0] result_d, result_q;

  // delay line, newest sample at position 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS; i++) hist_q[i] <= '0;
    end else if (ctrl_i.push) begin
      hist_q[0] <= sample_i;
      for (int i = 1; i < MAX_TAPS; i++) hist_q[i] <= hist_q[i-1];
    end
  end

  // coefficient lookup
  assign rom_idx = ROM_IDX_W'(32'(tap_idx_i));
  assign rom_q   = ctrl_i.lowpass ? lp_coef(rom_idx) : hp_coef(rom_idx);

  // rescale Q1.17 to the configured coefficient width
  if (COEF_WIDTH >= ROM_WIDTH) begin : g_scale_up
    assign coef = COEF_WIDTH'(rom_q) <<< (COEF_WIDTH - ROM_WIDTH);
  end else begin : g_scale_dn
    localparam logic signed [ROM_WIDTH-1:0] RomDiv = ROM_WIDTH'(1) <<< (ROM_WIDTH - COEF_WIDTH);
    assign coef = COEF_WIDTH'(rom_q / RomDiv);
  end

  // multiply stage
  assign prod_d = PW'(coef) * PW'(hist_q[tap_idx_i]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= prod_d;
    end
  end

  // saturating accumulate
  assign sum = (AccW+1)'(acc_q) + (AccW+1)'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      if (sum[AccW] != sum[AccW-1]) begin
        acc_d = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      end else begin
        acc_d = sum[AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // truncate toward zero, then clamp to the sample range
  assign biased = acc_q + (acc_q[AccW-1] ? $signed(BiasMask) : $signed({AccW{1'b0}}));
  assign quot   = QW'(biased >>> FracW);

  always_comb begin
    if (quot > SatMax) begin
      sat_val = SatMax[SAMPLE_WIDTH-1:0];
    end else if (quot < SatMin) begin
      sat_val = SatMin[SAMPLE_WIDTH-1:0];
    end else begin
      sat_val = quot[SAMPLE_WIDTH-1:0];
    end
  end

  // lane result
  assign result_d = ctrl_i.bypass ? hist_q[0] : sat_val;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ===== rtl/sfir_merge.sv =====
// ----------------------------------------------------------------------------
// sfir_merge: output stage
// Joins the two lane results into one stereo transaction and holds it in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module sfir_merge
  import sfir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_i,
  output logic                           free_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_o
);

  logic                           valid_q;
  logic signed [SAMPLE_WIDTH-1:0] left_q, right_q;

  // register is free when empty or being emptied this cycle
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q  <= left_i;
      right_q <= right_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_left_o  = left_q;
  assign out_right_o = right_q;

endmodule

// ===== tb/sfir_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfir_checker: result predictor and comparator for the stereo switchable FIR
// Watches the frame and result channels, keeps its own copy of both delay
// lines, predicts the stereo result of every accepted frame and compares each
// returned result, field by field, with the oldest prediction still due.
// ----------------------------------------------------------------------------
module sfir_checker
  import sfir_pkg::*;
#(
  parameter int SW = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic signed [SW-1:0] sample_left_i,
  input  logic signed [SW-1:0] sample_right_i,
  input  logic [1:0]           kind_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic signed [SW-1:0] out_left_i,
  input  logic signed [SW-1:0] out_right_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int     DEPTH     = MAX_TAPS_DEF;
  localparam int     FRAC_BITS = COEF_WIDTH_DEF - 1;
  localparam longint OUT_MAX   = (longint'(1) << (SW - 1)) - 1;
  localparam longint OUT_MIN   = -(longint'(1) << (SW - 1));

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } stereo_t;

  // coefficient tables, q1.17, already at the default coefficient width
  int lp_table [LP_LEN] = '{
    -2218, 6611, 5159, 5690, 6734, 7841, 8846, 9672, 10256, 10555,
    10555, 10256, 9672, 8846, 7841, 6734, 5690, 5159, 6611, -2218
  };
  int hp_table [HP_LEN] = '{
    -5167, -777, 1876, 5333, 7553, 6349, 570, -9087, -20026, -28670,
    99118,
    -28670, -20026, -9087, 570, 6349, 7553, 5333, 1876, -777, -5167
  };

  // delay lines, newest sample at index 0
  logic signed [SW-1:0] left_line  [DEPTH];
  logic signed [SW-1:0] right_line [DEPTH];

  stereo_t due_frames [$];
  stereo_t next_due;
  stereo_t head;

  task automatic report_mismatch(input string msg);
    $display("[%0t] sfir_checker: %s", $time, msg);
    fail_count_o++;
  endtask

  // one channel through the selected table: truncate toward zero, then clamp
  function automatic logic signed [SW-1:0] filter_channel(input bit right_ch,
                                                          input bit use_lowpass);
    longint acc;
    longint coef;
    longint tap;
    int     n_taps;
    acc    = 0;
    n_taps = use_lowpass ? LOWPASS_TAPS_DEF : DEPTH;
    if (use_lowpass && n_taps > LP_LEN) n_taps = LP_LEN;
    if (!use_lowpass && n_taps > HP_LEN) n_taps = HP_LEN;
    if (n_taps > DEPTH) n_taps = DEPTH;
    // sums stay far inside 64 bits at these widths
    for (int k = 0; k < n_taps; k++) begin
      coef = use_lowpass ? lp_table[k] : hp_table[k];
      tap  = right_ch ? right_line[k] : left_line[k];
      acc += coef * tap;
    end
    acc = acc / (longint'(1) << FRAC_BITS);
    if (acc > OUT_MAX) acc = OUT_MAX;
    if (acc < OUT_MIN) acc = OUT_MIN;
    return acc[SW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
      due_frames.delete();
      pending_o <= 0;
    end else begin
      // result transaction against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (due_frames.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with no frame waiting",
                                    out_left_i, out_right_i));
        end else begin
          head = due_frames.pop_front();
          if (out_left_i !== head.left)
            report_mismatch($sformatf("out_left got %0d expected %0d",
                                      out_left_i, head.left));
          if (out_right_i !== head.right)
            report_mismatch($sformatf("out_right got %0d expected %0d",
                                      out_right_i, head.right));
        end
      end
      // frame transaction: shift in every mode, then predict
      if (in_valid_i && in_ready_i) begin
        for (int i = DEPTH - 1; i > 0; i--) begin
          left_line[i]  = left_line[i-1];
          right_line[i] = right_line[i-1];
        end
        left_line[0]  = sample_left_i;
        right_line[0] = sample_right_i;
        if (kind_i[KIND_LP_BIT]) begin
          next_due.left  = filter_channel(1'b0, 1'b1);
          next_due.right = filter_channel(1'b1, 1'b1);
        end else if (kind_i[KIND_HP_BIT]) begin
          next_due.left  = filter_channel(1'b0, 1'b0);
          next_due.right = filter_channel(1'b1, 1'b0);
        end else begin
          next_due.left  = sample_left_i;
          next_due.right = sample_right_i;
        end
        due_frames.push_back(next_due);
      end
      pending_o <= due_frames.size();
    end
  end

endmodule

// ===== tb/tb_stereo_switchable_fir.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_switchable_fir: regression for the stereo switchable FIR
// Drives directed frames (extremes, every filter mode, saturation, tiny
// values) and then random frame sequences under three idling profiles,
// including a long receiver hold-off and full drains; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_stereo_switchable_fir;
  import sfir_pkg::*;

  localparam int SW            = SAMPLE_WIDTH_DEF;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_FRAMES  = 130;
  localparam int PATTERN_LEN   = HP_LEN;

  localparam logic [1:0] KIND_BYPASS   = 2'b00;
  localparam logic [1:0] KIND_LOWPASS  = 2'b01 << KIND_LP_BIT;
  localparam logic [1:0] KIND_HIGHPASS = 2'b01 << KIND_HP_BIT;
  localparam logic [1:0] KIND_BOTH     = KIND_LOWPASS | KIND_HIGHPASS;

  localparam logic signed [SW-1:0] FULL_POS = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] FULL_NEG = {1'b1, {(SW-1){1'b0}}};

  // high-pass taps with a negative coefficient, tap 0 at bit 0
  localparam logic [PATTERN_LEN-1:0] HP_NEG_TAPS = 21'h183B83;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic signed [SW-1:0] sample_left_i  = '0;
  logic signed [SW-1:0] sample_right_i = '0;
  logic [1:0]           kind_i         = KIND_BYPASS;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic signed [SW-1:0] out_left_o;
  logic signed [SW-1:0] out_right_o;

  int fail_count;
  int results_pending;
  int cycle_count   = 0;
  int send_idle_pct = 29;
  int recv_idle_pct = 54;
  int stall_trigger = 0;

  stereo_switchable_fir u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_left_i (sample_left_i),
    .sample_right_i(sample_right_i),
    .kind_i        (kind_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_left_o    (out_left_o),
    .out_right_o   (out_right_o)
  );

  sfir_checker #(.SW(SW)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .sample_left_i (sample_left_i),
    .sample_right_i(sample_right_i),
    .kind_i        (kind_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_left_i    (out_left_o),
    .out_right_i   (out_right_o),
    .fail_count_o  (fail_count),
    .pending_o     (results_pending)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stereo_switchable_fir regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on each trigger
  initial begin : receiver
    int hold_left;
    int trigger_seen;
    hold_left    = 0;
    trigger_seen = 0;
    forever begin
      @(posedge clk_i);
      if (trigger_seen != stall_trigger) begin
        trigger_seen = stall_trigger;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // one frame transaction; valid stays high unless an idle gap follows
  task automatic send_frame(input logic signed [SW-1:0] frame_l,
                            input logic signed [SW-1:0] frame_r,
                            input logic [1:0]           frame_kind);
    in_valid_i     <= 1'b1;
    sample_left_i  <= frame_l;
    sample_right_i <= frame_r;
    kind_i         <= frame_kind;
    do @(posedge clk_i); while (!in_ready_o);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  endtask

  // stop offering frames until every result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // random frame sequences, mostly shaped to reach saturation and rounding
  task automatic run_random(input int n_frames);
    int                   sent;
    int                   pick;
    int                   run_len;
    bit                   flip;
    logic signed [SW-1:0] frame_l;
    logic signed [SW-1:0] frame_r;
    sent = 0;
    while (sent < n_frames) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // full-range noise in any mode
        run_len = $urandom_range(1, 12);
        repeat (run_len) begin
          send_frame(SW'($urandom), SW'($urandom), 2'($urandom_range(0, 3)));
          sent++;
        end
      end else if (pick < 65) begin
        // long run of full-scale values fills the delay lines
        frame_l = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
        frame_r = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
        run_len = $urandom_range(15, 25);
        repeat (run_len) begin
          send_frame(frame_l, frame_r, 2'($urandom_range(0, 3)));
          sent++;
        end
      end else if (pick < 80) begin
        // sign pattern matched to the high-pass taps drives it into clamping
        flip = $urandom_range(0, 1);
        for (int j = 0; j < PATTERN_LEN; j++) begin
          frame_l = (HP_NEG_TAPS[j] ^ flip) ? FULL_NEG : FULL_POS;
          frame_r = (HP_NEG_TAPS[j] ^ flip) ? FULL_POS : FULL_NEG;
          send_frame(frame_l, frame_r, KIND_HIGHPASS);
          sent++;
        end
      end else begin
        // values near zero: truncation of small negative sums
        run_len = $urandom_range(1, 10);
        repeat (run_len) begin
          send_frame(SW'($urandom_range(0, 8) - 4), SW'($urandom_range(0, 8) - 4),
                     2'($urandom_range(0, 3)));
          sent++;
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bypass at both extremes
    send_frame(FULL_POS, FULL_NEG, KIND_BYPASS);
    send_frame(FULL_NEG, FULL_POS, KIND_BYPASS);
    // tiny values through high-pass and through both bits set
    send_frame(SW'(1), -SW'(1), KIND_HIGHPASS);
    send_frame(-SW'(1), SW'(1), KIND_BOTH);
    // full-scale run pushes the low-pass into clamping on both sides
    for (int i = 0; i < 18; i++)
      send_frame(FULL_POS, FULL_NEG, (i % 2) ? KIND_BOTH : KIND_LOWPASS);
    send_frame(FULL_POS, FULL_NEG, KIND_HIGHPASS);
    send_frame(FULL_NEG, FULL_POS, KIND_HIGHPASS);
    wait_for_results();

    // three idling profiles; the second opens with a long receiver hold-off
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 29;
          stall_trigger++;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_random(PHASE_FRAMES);
      wait_for_results();
    end

    if (fail_count == 0) begin
      $display("stereo_switchable_fir regression: pass");
    end else begin
      $display("stereo_switchable_fir regression: fail");
    end
    $finish;
  end

endmodule
